/* rtl/ppsb_pkg.sv */
// Package for the palette pixel shade and blend block.
// Holds the register codes, color masks and shared types; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppsb_pkg;

  localparam int unsigned IdxW    = 8;
  localparam int unsigned ColorW  = 16;
  localparam int unsigned PixW    = 24;
  localparam int unsigned BrightW = 13;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 16;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_PIXEL_FORMAT    = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_PALETTE_PRESENT = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_BRIGHTNESS      = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_TINT_ENABLE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_TINT_COLOR      = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_BLEND_MODE      = 3'd5;

  // Pixel formats.
  localparam logic [1:0] FMT_INDEX  = 2'd0;
  localparam logic [1:0] FMT_RGB565 = 2'd1;
  localparam logic [1:0] FMT_RGB888 = 2'd2;
  localparam logic [1:0] FMT_NONE   = 2'd3;

  // Blend modes; the unused codes act as opaque.
  localparam logic [2:0] BLEND_OPAQUE = 3'd0;
  localparam logic [2:0] BLEND_SRC25  = 3'd1;
  localparam logic [2:0] BLEND_SRC50  = 3'd2;
  localparam logic [2:0] BLEND_SRC75  = 3'd3;
  localparam logic [2:0] BLEND_DARKEN = 3'd4;

  // Command codes.
  localparam logic CMD_SHADE = 1'b0;
  localparam logic CMD_WRITE = 1'b1;

  localparam logic [ColorW-1:0]  HALF_MASK    = 16'h7BEF;
  localparam logic [ColorW-1:0]  QUARTER_MASK = 16'h39E7;
  localparam logic [BrightW-1:0] BRIGHT_UNITY = 13'd1000;

  // floor(v / 1000) == (v * RECIP_MUL) >> RECIP_SHIFT for every v below 2^19.
  localparam logic [19:0]  RECIP_MUL   = 20'd536871;
  localparam int unsigned  RECIP_SHIFT = 29;

  localparam logic [4:0] RB_MAX = 5'd31;
  localparam logic [5:0] G_MAX  = 6'd63;

  typedef struct packed {
    logic [4:0] r;
    logic [5:0] g;
    logic [4:0] b;
  } rgb565_t;

  typedef struct packed {
    logic [BrightW-1:0] brightness;
    logic               scale_on;
    logic               tint_on;
    rgb565_t            tint;
  } shade_cfg_t;

  // Load enables of the pipeline stages behind the palette read.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
  } stage_en_t;

endpackage

`default_nettype wire

/* rtl/ppsb_ram.sv */
// Generic single-port-write, registered-read RAM.
// No dependencies; the read data holds while the read enable is low.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* rtl/ppsb_shade.sv */
// Brightness scaling and tint stages of the palette shading pipeline.
// Depends on ppsb_pkg; the divide by 1000 is a reciprocal multiply.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_shade import ppsb_pkg::*; (
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  shade_cfg_t        cfg_i,
  input  rgb565_t           color_i,
  input  logic [ColorW-1:0] dest_i,
  input  logic              bypass_i,
  input  logic [PixW-1:0]   bypass_val_i,
  output rgb565_t           color_o,
  output logic [ColorW-1:0] dest_o,
  output logic              bypass_o,
  output logic [PixW-1:0]   bypass_val_o
);

  // Stage two: channel times brightness.
  rgb565_t           raw_q;
  logic [17:0]       prod_r_q;
  logic [18:0]       prod_g_q;
  logic [17:0]       prod_b_q;
  logic [ColorW-1:0] dest2_q;
  logic              byp2_q;
  logic [PixW-1:0]   bypv2_q;

  always_ff @(posedge clk_i) begin
    if (en_i.s2) begin
      raw_q    <= color_i;
      prod_r_q <= 18'(color_i.r) * 18'(cfg_i.brightness);
      prod_g_q <= 19'(color_i.g) * 19'(cfg_i.brightness);
      prod_b_q <= 18'(color_i.b) * 18'(cfg_i.brightness);
      dest2_q  <= dest_i;
      byp2_q   <= bypass_i;
      bypv2_q  <= bypass_val_i;
    end
  end

  // Stage three: quotient, saturation and tint average.
  logic [38:0] mul_r, mul_g, mul_b;
  logic [9:0]  quo_r, quo_g, quo_b;
  rgb565_t     scaled;
  logic [5:0]  sum_r, sum_b;
  logic [6:0]  sum_g;
  rgb565_t     color_d;

  always_comb begin
    mul_r = 39'(prod_r_q) * 39'(RECIP_MUL);
    mul_g = 39'(prod_g_q) * 39'(RECIP_MUL);
    mul_b = 39'(prod_b_q) * 39'(RECIP_MUL);
    quo_r = mul_r[RECIP_SHIFT +: 10];
    quo_g = mul_g[RECIP_SHIFT +: 10];
    quo_b = mul_b[RECIP_SHIFT +: 10];

    scaled = raw_q;
    if (cfg_i.scale_on) begin
      scaled.r = (quo_r > 10'(RB_MAX)) ? RB_MAX : quo_r[4:0];
      scaled.g = (quo_g > 10'(G_MAX))  ? G_MAX  : quo_g[5:0];
      scaled.b = (quo_b > 10'(RB_MAX)) ? RB_MAX : quo_b[4:0];
    end

    sum_r = 6'(scaled.r) + 6'(cfg_i.tint.r);
    sum_g = 7'(scaled.g) + 7'(cfg_i.tint.g);
    sum_b = 6'(scaled.b) + 6'(cfg_i.tint.b);

    color_d = scaled;
    if (cfg_i.tint_on) begin
      color_d.r = sum_r[5:1];
      color_d.g = sum_g[6:1];
      color_d.b = sum_b[5:1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s3) begin
      color_o      <= color_d;
      dest_o       <= dest2_q;
      bypass_o     <= byp2_q;
      bypass_val_o <= bypv2_q;
    end
  end

endmodule

`default_nettype wire

/* rtl/ppsb_blend.sv */
// Blend stage and output register of the palette shading pipeline.
// Depends on ppsb_pkg for the masks and blend mode codes.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_blend import ppsb_pkg::*; (
  input  logic              clk_i,
  input  stage_en_t         en_i,
  input  logic [2:0]        mode_i,
  input  rgb565_t           color_i,
  input  logic [ColorW-1:0] dest_i,
  input  logic              bypass_i,
  input  logic [PixW-1:0]   bypass_val_i,
  output logic [PixW-1:0]   pixel_o
);

  logic [ColorW-1:0] src;
  logic [ColorW-1:0] qd, qs, hd, hs;
  logic [17:0]       sum25, sum75;
  logic [ColorW-1:0] sum50;
  logic [31:0]       dark_prod;
  logic [ColorW-1:0] blended;
  logic [PixW-1:0]   pixel_d;
  logic [PixW-1:0]   pixel_q;

  always_comb begin
    src       = color_i;
    qd        = QUARTER_MASK & (dest_i >> 2);
    qs        = QUARTER_MASK & (src >> 2);
    hd        = HALF_MASK & (dest_i >> 1);
    hs        = HALF_MASK & (src >> 1);
    sum25     = 18'({qd, 1'b0}) + 18'(qd) + 18'(qs);
    sum75     = 18'({qs, 1'b0}) + 18'(qs) + 18'(qd);
    sum50     = hd + hs;
    dark_prod = 32'(dest_i & HALF_MASK) * 32'(src & HALF_MASK);

    case (mode_i)
      BLEND_SRC25:  blended = sum25[ColorW-1:0];
      BLEND_SRC50:  blended = sum50;
      BLEND_SRC75:  blended = sum75[ColorW-1:0];
      BLEND_DARKEN: blended = dark_prod[23:8] & HALF_MASK;
      default:      blended = src;
    endcase

    pixel_d = bypass_i ? bypass_val_i : PixW'(blended);
  end

  always_ff @(posedge clk_i) begin
    if (en_i.s4) begin
      pixel_q <= pixel_d;
    end
  end

  assign pixel_o = pixel_q;

endmodule

`default_nettype wire

/* rtl/palette_pixel_shade_blend.sv */
// Palette pixel shade and blend unit: top level.
// Depends on ppsb_pkg, ppsb_ram, ppsb_shade and ppsb_blend.
//
// Use: the input channel (in_valid_i / in_stall_o) carries one word per
// item, either a palette write (cmd_i set, src_index_i is the entry and
// palette_word_i the RGB565 color) or a pixel (cmd_i clear, src_index_i is
// the color index and dest_pixel_i the current RGB565 destination). A word
// is taken at a rising edge where in_valid_i is high and in_stall_o is low.
// Palette writes, index zero and pixel format 3 give no result word.
// Every other pixel gives one result word on the output channel
// (out_valid_o / out_stall_i, payload pixel_value_o), in input order.
//
// In order, a pixel passes the palette RAM read, the brightness product,
// the divide by 1000 with saturation and tint, and the blend stage feeding
// the output register. While out_stall_i is low the throughput is one word
// per clock; the pipeline and the palette RAM port each take one per cycle.
// A palette write may be followed at once by a pixel that reads it.
// When the receiver stalls, the result holds on the output and the stages
// behind it keep filling; in_stall_o rises only once every stage is full.
// Reset clears the stage valid bits and restores the register defaults;
// the palette holds garbage until written and needs no clearing pass.
// Configuration writes (cfg_we_i) take effect at once and should only be
// made while the pipeline is empty.
`timescale 1ns / 1ps
`default_nettype none

module palette_pixel_shade_blend import ppsb_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration port
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  // Input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               cmd_i,
  input  logic [IdxW-1:0]    src_index_i,
  input  logic [ColorW-1:0]  dest_pixel_i,
  input  logic [ColorW-1:0]  palette_word_i,
  // Output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PixW-1:0]    pixel_value_o
);

  localparam int unsigned AddrW = $clog2(PALETTE_ENTRIES);
  localparam logic [IdxW:0] EntriesW = (IdxW + 1)'(PALETTE_ENTRIES);

  // Configuration registers.
  logic [1:0]         fmt_q;
  logic               present_q;
  logic [BrightW-1:0] bright_q;
  logic               tint_en_q;
  logic [ColorW-1:0]  tint_q;
  logic [2:0]         blend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_RGB565;
      present_q <= 1'b1;
      bright_q  <= BRIGHT_UNITY;
      tint_en_q <= 1'b0;
      tint_q    <= '0;
      blend_q   <= BLEND_OPAQUE;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_PIXEL_FORMAT:    fmt_q     <= cfg_data_i[1:0];
        CFG_PALETTE_PRESENT: present_q <= cfg_data_i[0];
        CFG_BRIGHTNESS:      bright_q  <= cfg_data_i[BrightW-1:0];
        CFG_TINT_ENABLE:     tint_en_q <= cfg_data_i[0];
        CFG_TINT_COLOR:      tint_q    <= cfg_data_i;
        CFG_BLEND_MODE:      blend_q   <= cfg_data_i[2:0];
        default:             ;
      endcase
    end
  end

  // Stage valid bits and the ready chain; a stage takes a new word when it
  // is empty or its content moves on in the same cycle.
  logic v1_q, v2_q, v3_q, v4_q;
  logic r1, r2, r3, r4;

  assign r4 = !v4_q || !out_stall_i;
  assign r3 = !v3_q || r4;
  assign r2 = !v2_q || r3;
  assign r1 = !v1_q || r2;

  logic in_accept, idx_in_range, pix_accept, pal_write;

  assign in_accept    = in_valid_i && r1;
  assign idx_in_range = {1'b0, src_index_i} < EntriesW;
  assign pix_accept   = in_accept && (cmd_i == CMD_SHADE) && (src_index_i != '0)
                        && (fmt_q != FMT_NONE);
  assign pal_write    = in_accept && (cmd_i == CMD_WRITE) && idx_in_range;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      if (r1) v1_q <= pix_accept;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
    end
  end

  // Stage one: palette read, with the item's side data held alongside.
  logic [IdxW-1:0]   s1_idx_q;
  logic [ColorW-1:0] s1_dest_q;
  logic              s1_oob_q;
  logic [ColorW-1:0] ram_rdata;

  always_ff @(posedge clk_i) begin
    if (r1) begin
      s1_idx_q  <= src_index_i;
      s1_dest_q <= dest_pixel_i;
      s1_oob_q  <= !idx_in_range;
    end
  end

  ppsb_ram #(
    .Width (ColorW),
    .Depth (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (pal_write),
    .waddr_i (src_index_i[AddrW-1:0]),
    .wdata_i (palette_word_i),
    .re_i    (pix_accept),
    .raddr_i (src_index_i[AddrW-1:0]),
    .rdata_o (ram_rdata)
  );

  // An index past the end of the palette reads as black. Formats other than
  // RGB565, or no palette, skip shading and take a precomputed result.
  rgb565_t         s1_color;
  logic            s1_bypass;
  logic [PixW-1:0] s1_bypass_val;

  always_comb begin
    s1_color      = s1_oob_q ? '0 : ram_rdata;
    s1_bypass     = !present_q || (fmt_q != FMT_RGB565);
    s1_bypass_val = PixW'(s1_idx_q);
    if (present_q && (fmt_q == FMT_RGB888)) begin
      s1_bypass_val = {s1_color.r, 3'b000, s1_color.g, 2'b00, s1_color.b, 3'b000};
    end
  end

  stage_en_t  stage_en;
  shade_cfg_t shade_cfg;

  assign stage_en.s2 = r2;
  assign stage_en.s3 = r3;
  assign stage_en.s4 = r4;

  assign shade_cfg.brightness = bright_q;
  assign shade_cfg.scale_on   = (bright_q != '0) && (bright_q != BRIGHT_UNITY);
  assign shade_cfg.tint_on    = tint_en_q && (tint_q != '0);
  assign shade_cfg.tint       = tint_q;

  rgb565_t           s3_color;
  logic [ColorW-1:0] s3_dest;
  logic              s3_bypass;
  logic [PixW-1:0]   s3_bypass_val;

  ppsb_shade u_shade (
    .clk_i        (clk_i),
    .en_i         (stage_en),
    .cfg_i        (shade_cfg),
    .color_i      (s1_color),
    .dest_i       (s1_dest_q),
    .bypass_i     (s1_bypass),
    .bypass_val_i (s1_bypass_val),
    .color_o      (s3_color),
    .dest_o       (s3_dest),
    .bypass_o     (s3_bypass),
    .bypass_val_o (s3_bypass_val)
  );

  ppsb_blend u_blend (
    .clk_i        (clk_i),
    .en_i         (stage_en),
    .mode_i       (blend_q),
    .color_i      (s3_color),
    .dest_i       (s3_dest),
    .bypass_i     (s3_bypass),
    .bypass_val_i (s3_bypass_val),
    .pixel_o      (pixel_value_o)
  );

  assign in_stall_o  = !r1;
  assign out_valid_o = v4_q;

endmodule

`default_nettype wire

/* rtl/ppsb_checker.sv */
// Port-level checker for the palette pixel shade and blend unit.
// Bound to palette_pixel_shade_blend; depends on ppsb_pkg for widths.
`timescale 1ns / 1ps
`default_nettype none

module ppsb_checker import ppsb_pkg::*; (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic [PixW-1:0]    pixel_value_o
);

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_value_o))
    else $error("stalled result word changed");

  // The input side only stalls once a result word waits at the output.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled with the output empty");

  // A result leaving the output frees every stage behind it.
  a_drain_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i |-> !in_stall_o)
    else $error("input stalled while the output drains");

  // Nothing comes out of reset.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result word presented right after reset");

endmodule

bind palette_pixel_shade_blend ppsb_checker u_ppsb_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_stall_o     (in_stall_o),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_value_o  (pixel_value_o)
);

`default_nettype wire
